// File: rtl/icpg_pkg.sv
package icpg_pkg;

   localparam int LANES   = 2;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int NOW_W   = 32;
   localparam int INDEX_W = 10;
   localparam int COLOR_W = 32;
   localparam int PHASE_W = 8;
   localparam int COUNT_W = 7;
   localparam int TOTAL_W = 8;
   localparam int PAT_W   = 14;
   localparam int PER_W   = 16;
   localparam int MODE_W  = 4;

   localparam logic KIND_TIME  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MIN  = 7'd1;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd120;
   localparam logic [PER_W-1:0]   PERIOD_MIN = 16'd20;
   localparam logic [PER_W-1:0]   PERIOD_MAX = 16'd60000;

   localparam logic [PAT_W-1:0]   PATTERN_RESET    = 14'd129;
   localparam logic [COLOR_W-1:0] COLOR_EVEN_RESET = 32'h00FF_0000;
   localparam logic [COLOR_W-1:0] COLOR_ODD_RESET  = 32'h0000_00FF;
   localparam logic [PER_W-1:0]   PERIOD_RESET     = 16'd100;

   typedef enum logic [2:0] {
      REG_PATTERN_EVEN = 3'd0,
      REG_PATTERN_ODD  = 3'd1,
      REG_COLOR_EVEN   = 3'd2,
      REG_COLOR_ODD    = 3'd3,
      REG_PERIOD_EVEN  = 3'd4,
      REG_PERIOD_ODD   = 3'd5,
      REG_MODE_FLAGS   = 3'd6
   } reg_addr_type;

endpackage

// File: rtl/icpg_req_if.sv
interface icpg_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [icpg_pkg::NOW_W-1:0]    now_ms;
   logic [icpg_pkg::INDEX_W-1:0]  pixel_index;

   modport source (output valid, output kind, output now_ms, output pixel_index,
                   input ready);
   modport sink (input valid, input kind, input now_ms, input pixel_index,
                 output ready);
endinterface

// File: rtl/icpg_rsp_if.sv
interface icpg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [icpg_pkg::COLOR_W-1:0]  pixel_color;

   modport source (output valid, output pixel_color, input ready);
   modport sink (input valid, input pixel_color, output ready);
endinterface

// File: rtl/interleaved_chase_pattern_generator_top.sv
// A time word occupies the block for a load, a bit-serial division of the elapsed time
// by each channel's period (both channels side by side) and an update. A pixel word is
// reduced bit-serially modulo its channel's pattern length; its colour is registered
// in an output state that waits while an earlier result is untaken, and the next word
// enters only when the block is idle. Reset is synchronous and active high; it restores
// every configuration register to its documented value and clears both phases and times.
module interleaved_chase_pattern_generator_top #(
   parameter int MAX_PIXELS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   icpg_req_if.sink                      req,
   icpg_rsp_if.source                    rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [icpg_pkg::ADDR_W-1:0]   paddr,
   input  logic [icpg_pkg::DATA_W-1:0]   pwdata,
   output logic [icpg_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   localparam int DIV_STEPS = icpg_pkg::NOW_W;
   localparam int SUM_W     = icpg_pkg::INDEX_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_UPD   = 5'b00100,
      ST_PIX   = 5'b01000,
      ST_PDONE = 5'b10000
   } state_type;

   function automatic logic [icpg_pkg::COUNT_W-1:0] clamp_count(
      input logic [icpg_pkg::COUNT_W-1:0] v);
      logic [icpg_pkg::COUNT_W-1:0] r;
      r = v;
      if (v < icpg_pkg::COUNT_MIN) r = icpg_pkg::COUNT_MIN;
      else if (v > icpg_pkg::COUNT_MAX) r = icpg_pkg::COUNT_MAX;
      return r;
   endfunction

   function automatic logic [icpg_pkg::PER_W-1:0] clamp_period(
      input logic [icpg_pkg::PER_W-1:0] v);
      logic [icpg_pkg::PER_W-1:0] r;
      r = v;
      if (v < icpg_pkg::PERIOD_MIN) r = icpg_pkg::PERIOD_MIN;
      else if (v > icpg_pkg::PERIOD_MAX) r = icpg_pkg::PERIOD_MAX;
      return r;
   endfunction

   // One step of an MSB-first modulo reduction; r is always below m.
   function automatic logic [icpg_pkg::TOTAL_W-1:0] mod_shift(
      input logic [icpg_pkg::TOTAL_W-1:0] r, input logic b,
      input logic [icpg_pkg::TOTAL_W-1:0] m);
      logic [icpg_pkg::TOTAL_W:0] v;
      logic [icpg_pkg::TOTAL_W:0] d;
      v = {r, b};
      d = v - {1'b0, m};
      if (v >= {1'b0, m}) return d[icpg_pkg::TOTAL_W-1:0];
      else return v[icpg_pkg::TOTAL_W-1:0];
   endfunction

   logic [icpg_pkg::LANES-1:0][icpg_pkg::PAT_W-1:0]    pattern_ff, pattern_in;
   logic [icpg_pkg::LANES-1:0][icpg_pkg::COLOR_W-1:0]  color_ff, color_in;
   logic [icpg_pkg::LANES-1:0][icpg_pkg::PER_W-1:0]    period_ff, period_in;
   logic [icpg_pkg::MODE_W-1:0]                        mode_ff, mode_in;

   logic [icpg_pkg::LANES-1:0][icpg_pkg::COUNT_W-1:0]  on_c;
   logic [icpg_pkg::LANES-1:0][icpg_pkg::COUNT_W-1:0]  off_c;
   logic [icpg_pkg::LANES-1:0][icpg_pkg::TOTAL_W-1:0]  total_c;
   logic [icpg_pkg::LANES-1:0][icpg_pkg::PER_W-1:0]    period_c;

   state_type                                          state_ff, state_in;
   logic [CNT_W-1:0]                                   cnt_ff, cnt_in;
   logic [icpg_pkg::NOW_W-1:0]                         now_ff, now_in;

   logic [icpg_pkg::LANES-1:0][icpg_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [icpg_pkg::LANES-1:0][icpg_pkg::NOW_W-1:0]    last_ff, last_in;
   logic [icpg_pkg::LANES-1:0][icpg_pkg::NOW_W-1:0]    elapsed_ff, elapsed_in;
   logic [icpg_pkg::LANES-1:0][icpg_pkg::PER_W-1:0]    rem_ff, rem_in;
   logic [icpg_pkg::LANES-1:0][icpg_pkg::TOTAL_W-1:0]  step_ff, step_in;
   logic [icpg_pkg::LANES-1:0][icpg_pkg::TOTAL_W-1:0]  pmod_ff, pmod_in;
   logic [icpg_pkg::LANES-1:0][icpg_pkg::PHASE_W-1:0]  pshift_ff, pshift_in;
   logic [icpg_pkg::LANES-1:0]                         qnz_ff, qnz_in;
   logic [icpg_pkg::LANES-1:0]                         run_ff, run_in;

   logic                                               ch_ff, ch_in;
   logic                                               inrange_ff, inrange_in;
   logic [SUM_W-1:0]                                   psum_ff, psum_in;
   logic [icpg_pkg::TOTAL_W-1:0]                       pacc_ff, pacc_in;

   logic                                               rsp_valid_ff, rsp_valid_in;
   logic [icpg_pkg::COLOR_W-1:0]                       rsp_color_ff, rsp_color_in;

   logic                                               cfg_write;
   icpg_pkg::reg_addr_type                             cfg_addr;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_addr  = icpg_pkg::reg_addr_type'(paddr[icpg_pkg::ADDR_W-1:2]);

   always_comb begin
      pattern_in = pattern_ff;
      color_in   = color_ff;
      period_in  = period_ff;
      mode_in    = mode_ff;
      if (cfg_write) begin
         unique case (cfg_addr)
            icpg_pkg::REG_PATTERN_EVEN: pattern_in[0] = pwdata[icpg_pkg::PAT_W-1:0];
            icpg_pkg::REG_PATTERN_ODD:  pattern_in[1] = pwdata[icpg_pkg::PAT_W-1:0];
            icpg_pkg::REG_COLOR_EVEN:   color_in[0]   = pwdata[icpg_pkg::COLOR_W-1:0];
            icpg_pkg::REG_COLOR_ODD:    color_in[1]   = pwdata[icpg_pkg::COLOR_W-1:0];
            icpg_pkg::REG_PERIOD_EVEN:  period_in[0]  = pwdata[icpg_pkg::PER_W-1:0];
            icpg_pkg::REG_PERIOD_ODD:   period_in[1]  = pwdata[icpg_pkg::PER_W-1:0];
            icpg_pkg::REG_MODE_FLAGS:   mode_in       = pwdata[icpg_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_addr)
         icpg_pkg::REG_PATTERN_EVEN: prdata = 32'(pattern_ff[0]);
         icpg_pkg::REG_PATTERN_ODD:  prdata = 32'(pattern_ff[1]);
         icpg_pkg::REG_COLOR_EVEN:   prdata = 32'(color_ff[0]);
         icpg_pkg::REG_COLOR_ODD:    prdata = 32'(color_ff[1]);
         icpg_pkg::REG_PERIOD_EVEN:  prdata = 32'(period_ff[0]);
         icpg_pkg::REG_PERIOD_ODD:   prdata = 32'(period_ff[1]);
         icpg_pkg::REG_MODE_FLAGS:   prdata = 32'(mode_ff);
         default:                    prdata = '0;
      endcase
   end

   always_comb begin
      for (int l = 0; l < icpg_pkg::LANES; l++) begin
         on_c[l]     = clamp_count(pattern_ff[l][icpg_pkg::COUNT_W-1:0]);
         off_c[l]    = clamp_count(pattern_ff[l][icpg_pkg::PAT_W-1:icpg_pkg::COUNT_W]);
         total_c[l]  = icpg_pkg::TOTAL_W'(on_c[l]) + icpg_pkg::TOTAL_W'(off_c[l]);
         period_c[l] = clamp_period(period_ff[l]);
      end
   end

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_color = rsp_color_ff;

   always_comb begin
      logic [icpg_pkg::PER_W:0]     trial;
      logic [icpg_pkg::PER_W:0]     trial_sub;
      logic                         q;
      logic [icpg_pkg::TOTAL_W:0]   sum;
      logic [icpg_pkg::TOTAL_W:0]   nxt;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      now_in       = now_ff;
      phase_in     = phase_ff;
      last_in      = last_ff;
      elapsed_in   = elapsed_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      pmod_in      = pmod_ff;
      pshift_in    = pshift_ff;
      qnz_in       = qnz_ff;
      run_in       = run_ff;
      ch_in        = ch_ff;
      inrange_in   = inrange_ff;
      psum_in      = psum_ff;
      pacc_in      = pacc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      trial        = '0;
      trial_sub    = '0;
      q            = 1'b0;
      sum          = '0;
      nxt          = '0;

      if (rsp.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               cnt_in = '0;
               if (req.kind == icpg_pkg::KIND_TIME) begin
                  now_in = req.now_ms;
                  for (int l = 0; l < icpg_pkg::LANES; l++) begin
                     run_in[l]     = !mode_ff[2*l];
                     elapsed_in[l] = req.now_ms - last_ff[l];
                     rem_in[l]     = '0;
                     step_in[l]    = '0;
                     pmod_in[l]    = '0;
                     pshift_in[l]  = phase_ff[l];
                     qnz_in[l]     = 1'b0;
                     if (mode_ff[2*l]) last_in[l] = req.now_ms;
                  end
                  state_in = ST_DIV;
               end else begin
                  ch_in      = req.pixel_index[0];
                  inrange_in = (32'(req.pixel_index) < 32'(MAX_PIXELS));
                  psum_in    = SUM_W'(phase_ff[req.pixel_index[0]])
                             + SUM_W'(req.pixel_index[icpg_pkg::INDEX_W-1:1]);
                  pacc_in    = '0;
                  state_in   = ST_PIX;
               end
            end
         end
         ST_DIV: begin
            for (int l = 0; l < icpg_pkg::LANES; l++) begin
               trial     = {rem_ff[l], elapsed_ff[l][icpg_pkg::NOW_W-1]};
               trial_sub = trial - {1'b0, period_c[l]};
               q         = (trial >= {1'b0, period_c[l]});
               rem_in[l] = q ? trial_sub[icpg_pkg::PER_W-1:0] : trial[icpg_pkg::PER_W-1:0];
               elapsed_in[l] = {elapsed_ff[l][icpg_pkg::NOW_W-2:0], 1'b0};
               step_in[l]    = mod_shift(step_ff[l], q, total_c[l]);
               qnz_in[l]     = qnz_ff[l] | q;
               if (cnt_ff < CNT_W'(icpg_pkg::PHASE_W)) begin
                  pmod_in[l]   = mod_shift(pmod_ff[l], pshift_ff[l][icpg_pkg::PHASE_W-1],
                                           total_c[l]);
                  pshift_in[l] = {pshift_ff[l][icpg_pkg::PHASE_W-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = ST_UPD;
         end
         ST_UPD: begin
            for (int l = 0; l < icpg_pkg::LANES; l++) begin
               if (mode_ff[2*l+1]) begin
                  sum = {1'b0, pmod_ff[l]} + {1'b0, step_ff[l]};
                  nxt = (sum >= {1'b0, total_c[l]}) ? sum - {1'b0, total_c[l]} : sum;
               end else if (pmod_ff[l] >= step_ff[l]) begin
                  nxt = {1'b0, pmod_ff[l]} - {1'b0, step_ff[l]};
               end else begin
                  nxt = {1'b0, pmod_ff[l]} + {1'b0, total_c[l]} - {1'b0, step_ff[l]};
               end
               if (run_ff[l] && qnz_ff[l]) begin
                  phase_in[l] = nxt[icpg_pkg::PHASE_W-1:0];
                  last_in[l]  = now_ff;
               end
            end
            state_in = ST_IDLE;
         end
         ST_PIX: begin
            pacc_in = mod_shift(pacc_ff, psum_ff[SUM_W-1], total_c[ch_ff]);
            psum_in = {psum_ff[SUM_W-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SUM_W - 1)) state_in = ST_PDONE;
         end
         ST_PDONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = (inrange_ff && (pacc_ff < icpg_pkg::TOTAL_W'(on_c[ch_ff])))
                            ? color_ff[ch_ff] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= {icpg_pkg::PATTERN_RESET, icpg_pkg::PATTERN_RESET};
         color_ff     <= {icpg_pkg::COLOR_ODD_RESET, icpg_pkg::COLOR_EVEN_RESET};
         period_ff    <= {icpg_pkg::PERIOD_RESET, icpg_pkg::PERIOD_RESET};
         mode_ff      <= '0;
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pattern_ff   <= pattern_in;
         color_ff     <= color_in;
         period_ff    <= period_in;
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      now_ff       <= now_in;
      elapsed_ff   <= elapsed_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      pmod_ff      <= pmod_in;
      pshift_ff    <= pshift_in;
      qnz_ff       <= qnz_in;
      run_ff       <= run_in;
      ch_ff        <= ch_in;
      inrange_ff   <= inrange_in;
      psum_ff      <= psum_in;
      pacc_ff      <= pacc_in;
      rsp_color_ff <= rsp_color_in;
   end

`ifndef SYNTHESIS
   a_rem_below_period: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff[0] < period_c[0]))
      else $error("division remainder not below the period");

   a_step_below_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff[1] < total_c[1]))
      else $error("frame step not reduced below the cycle length");

   a_phase_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && run_ff[0] && qnz_ff[0]) |=> (phase_ff[0] < total_c[0]))
      else $error("updated phase not below the cycle length");

   a_rsp_from_pdone: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PDONE))
      else $error("result word raised outside the output state");
`endif

endmodule

// File: verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import icpg_pkg::*;

   localparam int MAX_PIXELS    = 1024;
   localparam int SPARE_REG     = int'(REG_MODE_FLAGS) + 1;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_WORDS   = 85;

   logic                clock = 1'b0;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   icpg_req_if req_bus ();
   icpg_rsp_if rsp_bus ();

   interleaved_chase_pattern_generator_top #(
      .MAX_PIXELS (MAX_PIXELS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("tb_top failed");
      $finish;
   end

   // Shadow of the register file and of the chase state of both channels.
   logic [PAT_W-1:0]   pattern_q [LANES];
   logic [COLOR_W-1:0] color_q   [LANES];
   logic [PER_W-1:0]   period_q  [LANES];
   logic [MODE_W-1:0]  mode_q;
   logic [PHASE_W-1:0] phase_q   [LANES];
   logic [NOW_W-1:0]   last_ms_q [LANES];
   logic [NOW_W-1:0]   wall_ms;

   logic [COLOR_W-1:0] expected_colors [$];
   int                 fault_count   = 0;
   int                 send_idle_pct = 22;
   int                 recv_idle_pct = 62;
   int                 hold_asked    = 0;
   int                 hold_taken    = 0;
   int                 hold_left     = 0;

   function automatic int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int lit_span(int ch);
      return clamp(int'(pattern_q[ch][COUNT_W-1:0]), COUNT_MIN, COUNT_MAX);
   endfunction

   function automatic int total_count(int ch);
      return lit_span(ch) + clamp(int'(pattern_q[ch][PAT_W-1:COUNT_W]), COUNT_MIN, COUNT_MAX);
   endfunction

   function automatic int frame_ms(int ch);
      return clamp(int'(period_q[ch]), PERIOD_MIN, PERIOD_MAX);
   endfunction

   function automatic void restore_defaults();
      for (int ch = 0; ch < LANES; ch++) begin
         pattern_q[ch] = PATTERN_RESET;
         period_q[ch]  = PERIOD_RESET;
         phase_q[ch]   = '0;
         last_ms_q[ch] = '0;
      end
      color_q[0] = COLOR_EVEN_RESET;
      color_q[1] = COLOR_ODD_RESET;
      mode_q     = '0;
      wall_ms    = '0;
   endfunction

   function automatic void advance_chase(int ch, logic [NOW_W-1:0] now);
      logic [NOW_W-1:0] elapsed;
      logic [NOW_W-1:0] frames;
      int               total;
      int               step;
      if (!mode_q[2*ch]) begin
         total   = total_count(ch);
         elapsed = now - last_ms_q[ch];
         frames  = elapsed / NOW_W'(frame_ms(ch));
         if (frames == '0) return;
         step = int'(frames % NOW_W'(total));
         if (mode_q[2*ch+1])
            phase_q[ch] = PHASE_W'((int'(phase_q[ch]) + step) % total);
         else
            phase_q[ch] = PHASE_W'((int'(phase_q[ch]) + total - step) % total);
      end
      last_ms_q[ch] = now;
   endfunction

   function automatic logic [COLOR_W-1:0] chase_color(logic [INDEX_W-1:0] idx);
      int ch;
      int pos;
      ch = int'(idx[0]);
      if (int'(idx) >= MAX_PIXELS) return '0;
      pos = (int'(phase_q[ch]) + int'(idx >> 1)) % total_count(ch);
      return (pos < lit_span(ch)) ? color_q[ch] : '0;
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(7))
         0: return '0;
         1: return COUNT_MIN;
         2: return COUNT_MAX;
         3: return '1;
         4: return COUNT_W'($urandom_range(2, 5));
         default: return COUNT_W'($urandom_range(127));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_period();
      logic [DATA_W-1:0] v;
      v = $urandom;
      case ($urandom_range(9))
         0: v[PER_W-1:0] = '0;
         1: v[PER_W-1:0] = PERIOD_MIN - 16'd1;
         2: v[PER_W-1:0] = PERIOD_MIN;
         3: v[PER_W-1:0] = PERIOD_MAX;
         4: v[PER_W-1:0] = '1;
         5: v[PER_W-1:0] = PER_W'($urandom);
         default: v[PER_W-1:0] = PER_W'($urandom_range(20, 400));
      endcase
      return v;
   endfunction

   function automatic logic [NOW_W-1:0] next_now();
      int span;
      span = (frame_ms(0) > frame_ms(1)) ? frame_ms(0) : frame_ms(1);
      case ($urandom_range(15))
         0: return $urandom;
         1: return wall_ms + $urandom_range(19);
         2: return wall_ms - $urandom_range(1, 2000);
         default: return wall_ms + $urandom_range(6 * span);
      endcase
   endfunction

   task automatic report_fault(input string what, input logic [COLOR_W-1:0] want,
                               input logic [COLOR_W-1:0] got);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   // Receiver: random back-pressure, with an occasional long hold-off.
   always @(posedge clock) begin
      if (hold_asked != hold_taken) begin
         hold_left  = HOLD_CYCLES;
         hold_taken = hold_asked;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      logic [COLOR_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_colors.size() == 0) begin
            report_fault("unexpected result word", 'x, rsp_bus.pixel_color);
         end else begin
            want = expected_colors.pop_front();
            if (rsp_bus.pixel_color !== want)
               report_fault("pixel_color mismatch", want, rsp_bus.pixel_color);
         end
      end
   end

   task automatic csr_write(input int index, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(index * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         REG_PATTERN_EVEN: pattern_q[0] = value[PAT_W-1:0];
         REG_PATTERN_ODD:  pattern_q[1] = value[PAT_W-1:0];
         REG_COLOR_EVEN:   color_q[0]   = value[COLOR_W-1:0];
         REG_COLOR_ODD:    color_q[1]   = value[COLOR_W-1:0];
         REG_PERIOD_EVEN:  period_q[0]  = value[PER_W-1:0];
         REG_PERIOD_ODD:   period_q[1]  = value[PER_W-1:0];
         REG_MODE_FLAGS:   mode_q       = value[MODE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_release();
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_word(input logic kind, input logic [NOW_W-1:0] now,
                            input logic [INDEX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= kind;
      req_bus.now_ms      <= now;
      req_bus.pixel_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      if (kind == KIND_TIME) begin
         advance_chase(0, now);
         advance_chase(1, now);
         wall_ms = now;
      end else begin
         expected_colors.push_back(chase_color(idx));
      end
   endtask

   task automatic send_time(input logic [NOW_W-1:0] now);
      send_word(KIND_TIME, now, INDEX_W'($urandom));
   endtask

   task automatic send_pixel(input logic [INDEX_W-1:0] idx);
      send_word(KIND_PIXEL, $urandom, idx);
   endtask

   // A time word gives no result, so the block is left a little longer to finish it.
   task automatic idle_until_drained();
      req_bus.valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_random_settings();
      logic [DATA_W-1:0] v;
      for (int ch = 0; ch < LANES; ch++) begin
         v = $urandom;
         v[PAT_W-1:0] = {pick_count(), pick_count()};
         csr_write(int'(REG_PATTERN_EVEN) + ch, v);
         csr_write(int'(REG_COLOR_EVEN) + ch, $urandom);
         csr_write(int'(REG_PERIOD_EVEN) + ch, pick_period());
      end
      csr_write(REG_MODE_FLAGS, $urandom);
      if ($urandom_range(3) == 0)
         csr_write(SPARE_REG, $urandom);
      csr_release();
   endtask

   task automatic test_reset_state();
      send_pixel(0);
      send_pixel(1);
      send_pixel(2);
      send_time(99);
      send_pixel(0);
      send_time(100);
      send_pixel(3);
      idle_until_drained();
   endtask

   task automatic test_count_and_period_limits();
      csr_write(REG_PATTERN_EVEN, 32'h0);
      csr_write(REG_PATTERN_ODD, 32'hFFFF_FFFF);
      csr_write(REG_PERIOD_EVEN, 32'h0);
      csr_write(REG_PERIOD_ODD, 32'hFFFF_FFFF);
      csr_write(REG_COLOR_EVEN, 32'hFFFF_FFFF);
      csr_write(REG_COLOR_ODD, 32'h5555_AAAA);
      csr_write(SPARE_REG, 32'hFFFF_FFFF);
      csr_release();
      send_time(wall_ms + 32'd19);
      send_pixel(0);
      send_time(wall_ms + 32'd1);
      send_pixel(1022);
      send_pixel(1023);
      send_time(wall_ms + 32'd180_000);
      send_pixel(1);
      idle_until_drained();
   endtask

   task automatic test_stop_reverse_and_wrap();
      csr_write(REG_MODE_FLAGS, 32'b1001);
      csr_release();
      send_time(wall_ms + 32'd500);
      send_pixel(0);
      send_pixel(1);
      idle_until_drained();
      csr_write(REG_MODE_FLAGS, 32'b0110);
      csr_release();
      send_time(wall_ms - 32'd7);
      send_pixel(0);
      send_pixel(1);
      idle_until_drained();
   endtask

   task automatic test_phase_beyond_pattern();
      csr_write(REG_PATTERN_EVEN, {18'd0, COUNT_MAX, COUNT_MAX});
      csr_write(REG_PERIOD_EVEN, PERIOD_MIN);
      csr_write(REG_MODE_FLAGS, 32'h0);
      csr_release();
      send_time(wall_ms + 32'd100);
      idle_until_drained();
      csr_write(REG_PATTERN_EVEN, PATTERN_RESET);
      csr_release();
      send_pixel(0);
      send_pixel(2);
      idle_until_drained();
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_random_settings();
      hold_asked++;
      repeat (40) send_pixel(INDEX_W'($urandom));
      idle_until_drained();
      recv_idle_pct = 62;
      repeat (20) begin
         if ($urandom_range(3) == 0) send_time(next_now());
         else send_pixel(INDEX_W'($urandom));
      end
      idle_until_drained();
   endtask

   task automatic test_random_traffic();
      for (int pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin send_idle_pct = 22; recv_idle_pct = 62; end
            1: begin send_idle_pct = 62; recv_idle_pct = 22; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         repeat (6) begin
            apply_random_settings();
            repeat (PHASE_WORDS) begin
               if ($urandom_range(99) < 30) send_time(next_now());
               else send_pixel(INDEX_W'($urandom_range(1023)));
            end
            idle_until_drained();
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KIND_TIME;
      req_bus.now_ms      <= '0;
      req_bus.pixel_index <= '0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      restore_defaults();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_count_and_period_limits();
      test_stop_reverse_and_wrap();
      test_phase_beyond_pattern();
      test_output_backpressure();
      test_random_traffic();

      idle_until_drained();
      if (fault_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/icpg_pkg.sv
rtl/icpg_req_if.sv
rtl/icpg_rsp_if.sv
rtl/interleaved_chase_pattern_generator_top.sv
verif/tb_top.sv
